@@ hdl/ppgs_pkg.sv @@
package ppgs_pkg;

    // One pixel request
    typedef struct packed {
        logic [7:0] pixel_gray;
        logic       row_done;
        logic       image_done;
    } t_pix_req;

    // One segment result
    typedef struct packed {
        logic [9:0] seg_start;
        logic [9:0] seg_end;
        logic       seg_valid;
        logic       seg_last;
        logic       overflow;
    } t_seg_res;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAST     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_PAD     = 3'd5;

    // Register reset values
    localparam logic        RST_DIRECTION    = 1'b0;
    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [7:0]  RST_FG_THRESHOLD = 8'd125;
    localparam logic [10:0] RST_MIN_GAP      = 11'd15;
    localparam logic [10:0] RST_MIN_LAST     = 11'd3;
    localparam logic [3:0]  RST_EDGE_PAD     = 4'd1;

    // Gap counter saturation and closed-segment budget per image
    localparam logic [10:0] GAP_SAT    = 11'h7FF;
    localparam logic [5:0]  MAX_CLOSED = 6'd63;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic scan_rd;
        logic finish;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic dir_col;
        logic w_zero;
        logic clr_end;
        logic scan_end;
    } t_dp_stat;

endpackage

@@ hdl/ppgs_ctrl.sv @@
module ppgs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_image_done,
    input  ppgs_pkg::t_dp_stat   i_stat,
    output ppgs_pkg::t_ctrl_cmd  o_cmd,
    output logic                 o_busy
);
    import ppgs_pkg::*;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign accept = (r_state == ST_IDLE) && i_start;

    // Decode commands from the state
    always_comb begin
        o_cmd.accept  = accept;
        o_cmd.clr_wr  = (r_state == ST_CLR);
        o_cmd.scan_rd = (r_state == ST_SCAN);
        o_cmd.finish  = (r_state == ST_FIN);
    end

    assign o_busy = (r_state != ST_IDLE);

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR: begin
                if (i_stat.clr_end) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept && i_image_done) begin
                    if (i_stat.dir_col && !i_stat.w_zero) n_state = ST_SCAN;
                    else                                  n_state = ST_FIN;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_end) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLR;
        else          r_state <= n_state;
    end

endmodule

@@ hdl/ppgs_dp.sv @@
module ppgs_dp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ppgs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ppgs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  ppgs_pkg::t_pix_req                    i_req,
    input  ppgs_pkg::t_ctrl_cmd                   i_cmd,
    output ppgs_pkg::t_dp_stat                    o_stat,
    output ppgs_pkg::t_seg_res                    o_res,
    output logic                                  o_res_strobe
);
    import ppgs_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int LW = (AW > HW) ? AW : HW;
    localparam int TW = LW + 1;

    // Configuration registers
    logic        r_direction;
    logic [10:0] r_image_width;
    logic [7:0]  r_fg_thr;
    logic [10:0] r_min_gap;
    logic [10:0] r_min_last;
    logic [3:0]  r_edge_pad;

    // Scan position and line counters
    logic [CW-1:0] r_col_pos;
    logic [RW-1:0] r_row_pos;
    logic          r_line_fg;
    logic [AW-1:0] r_cnt;
    logic          r_rd_v;
    logic [AW-1:0] r_rd_idx;
    logic          r_mem_q;

    // Segment tracking
    logic          r_seg_open;
    logic [LW-1:0] r_seg_begin;
    logic [LW-1:0] r_last_fg;
    logic [10:0]   r_gap;
    logic [5:0]    r_emitted;
    logic          r_ovf;

    logic          n_seg_open;
    logic [LW-1:0] n_seg_begin;
    logic [LW-1:0] n_last_fg;
    logic [10:0]   n_gap;
    logic [5:0]    n_emitted;
    logic          n_ovf;

    // Result register
    t_seg_res      r_res;
    logic          r_res_v;
    t_seg_res      n_res;
    logic          n_res_v;

    // Column occupancy: one bit per column, set by any foreground pixel in column mode
    logic          r_colmap [MAX_WIDTH];

    logic [CW-1:0] w;
    logic          in_rows;
    logic          in_cols;
    logic          fg;
    logic          line_end;
    logic          feed_en;
    logic [LW-1:0] feed_idx;
    logic          feed_ne;
    logic [10:0]   mg;
    logic [LW-1:0] pad_start;
    logic [TW-1:0] pad_end;
    logic [TW-1:0] total;
    logic [TW-1:0] seg_len;
    logic          fin_ok;
    logic [TW-1:0] fin_end;
    logic          mem_we;
    logic          mem_wd;
    logic [AW-1:0] mem_addr;

    // Clamp the width in use to the column store
    always_comb begin
        if (32'(r_image_width) > 32'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
        else                                     w = CW'(r_image_width);
    end

    assign in_rows  = (r_row_pos < RW'(MAX_HEIGHT));
    assign in_cols  = (r_col_pos < w);
    assign fg       = in_rows && in_cols && (i_req.pixel_gray <= r_fg_thr);
    assign line_end = i_req.row_done || i_req.image_done;

    // Pick the line fed to the gap logic: a finished row or a scanned column
    assign feed_en  = (i_cmd.accept && !r_direction && line_end && in_rows) || r_rd_v;
    assign feed_idx = r_rd_v ? LW'(r_rd_idx) : LW'(r_row_pos);
    assign feed_ne  = r_rd_v ? r_mem_q : (r_line_fg || fg);
    assign mg       = (r_min_gap == '0) ? 11'd1 : r_min_gap;

    // Padded start and end of the current segment
    always_comb begin
        if (32'(r_seg_begin) >= 32'(r_edge_pad)) pad_start = r_seg_begin - LW'(r_edge_pad);
        else                                     pad_start = '0;
        pad_end = TW'(r_last_fg) + TW'(r_edge_pad);
        total   = r_direction ? TW'(w) : TW'(r_row_pos);
        seg_len = TW'(r_last_fg) - TW'(r_seg_begin) + TW'(1);
        fin_ok  = r_seg_open && (total != '0) && (32'(seg_len) >= 32'(r_min_last));
        if (pad_end > total - TW'(1)) fin_end = total - TW'(1);
        else                          fin_end = pad_end;
    end

    // Gap logic: open, extend or close segments, and issue results
    always_comb begin
        n_seg_open  = r_seg_open;
        n_seg_begin = r_seg_begin;
        n_last_fg   = r_last_fg;
        n_gap       = r_gap;
        n_emitted   = r_emitted;
        n_ovf       = r_ovf;
        n_res_v     = 1'b0;
        n_res       = r_res;

        if (feed_en) begin
            if (feed_ne) begin
                if (!r_seg_open) begin
                    n_seg_open  = 1'b1;
                    n_seg_begin = feed_idx;
                end else if (r_gap >= mg) begin
                    if (r_emitted < MAX_CLOSED) begin
                        n_res_v          = 1'b1;
                        n_res.seg_start  = 10'(pad_start);
                        if (pad_end > TW'(feed_idx)) n_res.seg_end = 10'(feed_idx);
                        else                         n_res.seg_end = 10'(pad_end);
                        n_res.seg_valid  = 1'b1;
                        n_res.seg_last   = 1'b0;
                        n_res.overflow   = r_ovf;
                        n_emitted        = r_emitted + 6'd1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_seg_begin = feed_idx;
                end
                n_last_fg = feed_idx;
                n_gap     = '0;
            end else if (r_seg_open && (r_gap < GAP_SAT)) begin
                n_gap = r_gap + 11'd1;
            end
        end

        // Final result of the image, then drop all per-image state
        if (i_cmd.finish) begin
            n_res_v        = 1'b1;
            n_res.seg_valid = fin_ok;
            n_res.seg_last  = 1'b1;
            n_res.overflow  = r_ovf;
            if (fin_ok) begin
                n_res.seg_start = 10'(pad_start);
                n_res.seg_end   = 10'(fin_end);
            end else begin
                n_res.seg_start = '0;
                n_res.seg_end   = '0;
            end
            n_seg_open  = 1'b0;
            n_seg_begin = '0;
            n_last_fg   = '0;
            n_gap       = '0;
            n_emitted   = '0;
            n_ovf       = 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction   <= RST_DIRECTION;
            r_image_width <= RST_IMAGE_WIDTH;
            r_fg_thr      <= RST_FG_THRESHOLD;
            r_min_gap     <= RST_MIN_GAP;
            r_min_last    <= RST_MIN_LAST;
            r_edge_pad    <= RST_EDGE_PAD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIRECTION:    r_direction   <= i_cfg_data[0];
                CFG_IMAGE_WIDTH:  r_image_width <= i_cfg_data;
                CFG_FG_THRESHOLD: r_fg_thr      <= i_cfg_data[7:0];
                CFG_MIN_GAP:      r_min_gap     <= i_cfg_data;
                CFG_MIN_LAST:     r_min_last    <= i_cfg_data;
                CFG_EDGE_PAD:     r_edge_pad    <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Pixel position and row occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
            r_line_fg <= 1'b0;
        end else if (i_cmd.finish) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
            r_line_fg <= 1'b0;
        end else if (i_cmd.accept) begin
            if (line_end) begin
                r_col_pos <= '0;
                r_line_fg <= 1'b0;
                if (in_rows) r_row_pos <= r_row_pos + RW'(1);
            end else begin
                if (r_col_pos < CW'(MAX_WIDTH)) r_col_pos <= r_col_pos + CW'(1);
                if (fg && !r_direction) r_line_fg <= 1'b1;
            end
        end
    end

    // Sweep counter for the clearing pass and the column scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_rd_v <= 1'b0;
        end else begin
            if (i_cmd.clr_wr || i_cmd.scan_rd) r_cnt <= r_cnt + AW'(1);
            else                               r_cnt <= '0;
            r_rd_v <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) r_rd_idx <= r_cnt;
    end

    // Column store: set on foreground, cleared by sweep and on read-out
    assign mem_we   = i_cmd.clr_wr || i_cmd.scan_rd || (i_cmd.accept && r_direction && fg);
    assign mem_wd   = !(i_cmd.clr_wr || i_cmd.scan_rd);
    assign mem_addr = (i_cmd.clr_wr || i_cmd.scan_rd) ? r_cnt : r_col_pos[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) r_colmap[mem_addr] <= mem_wd;
        if (i_cmd.scan_rd) r_mem_q <= r_colmap[r_cnt];
    end

    // Segment state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_open  <= 1'b0;
            r_seg_begin <= '0;
            r_last_fg   <= '0;
            r_gap       <= '0;
            r_emitted   <= '0;
            r_ovf       <= 1'b0;
            r_res_v     <= 1'b0;
        end else begin
            r_seg_open  <= n_seg_open;
            r_seg_begin <= n_seg_begin;
            r_last_fg   <= n_last_fg;
            r_gap       <= n_gap;
            r_emitted   <= n_emitted;
            r_ovf       <= n_ovf;
            r_res_v     <= n_res_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Status to the controller
    always_comb begin
        o_stat.dir_col  = r_direction;
        o_stat.w_zero   = (w == '0);
        o_stat.clr_end  = (r_cnt == AW'(MAX_WIDTH - 1));
        o_stat.scan_end = ((CW'(r_cnt) + CW'(1)) == w);
    end

    assign o_res        = r_res;
    assign o_res_strobe = r_res_v;

endmodule

@@ hdl/projection_profile_gap_segmenter_top.sv @@
// One pixel per cycle while busy is low; a segment closed by a row end shows in the
// cycle after that row's last pixel. At image end busy stays high through the finish
// state in row mode, and through a scan of W columns (one read per cycle), drain and
// finish in column mode (W: image_width clamped to MAX_WIDTH; W = 0 behaves as row
// mode). After reset busy stays high while the column store is cleared. Results are
// strobed for one cycle each; the receiver cannot stall.
module projection_profile_gap_segmenter_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ppgs_pkg::t_pix_req               i_req,
    output ppgs_pkg::t_seg_res               o_res,
    output logic                             o_res_strobe,
    input  logic                             i_cfg_we,
    input  logic [ppgs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ppgs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ppgs_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // Sequencer
    ppgs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_image_done (i_req.image_done),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_busy       (busy)
    );

    // Counters, column store and gap logic
    ppgs_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req        (i_req),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe)
    );

endmodule

@@ test/projection_profile_gap_segmenter_check.sv @@
module projection_profile_gap_segmenter_check #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  ppgs_pkg::t_pix_req               i_req,
    input  ppgs_pkg::t_seg_res               i_res,
    input  logic                             i_res_strobe,
    input  logic                             i_cfg_we,
    input  logic [ppgs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ppgs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_err_cnt,
    output int                               o_seg_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import ppgs_pkg::*;

    // Register copies
    logic        r_dir;
    logic [10:0] r_width;
    logic [7:0]  r_thr;
    logic [10:0] r_min_gap;
    logic [10:0] r_min_last;
    logic [3:0]  r_pad;

    // Profile state of the image in flight
    logic [10:0] col_fg [MAX_WIDTH];
    logic [10:0] row_fg;
    logic [10:0] col_pos;
    logic [10:0] row_pos;
    logic        seg_open;
    logic [9:0]  seg_first;
    logic [9:0]  fg_last;
    logic [10:0] gap_run;
    logic [6:0]  closed_cnt;
    logic        dropped;

    // Segments predicted but not yet seen on the result port
    t_seg_res owed_segs [$];

    function automatic string seg_text(input t_seg_res s);
        return $sformatf("start %0d end %0d valid %0b last %0b ovf %0b",
                         s.seg_start, s.seg_end, s.seg_valid, s.seg_last, s.overflow);
    endfunction

    function automatic void clear_image();
        foreach (col_fg[c]) col_fg[c] = '0;
        row_fg     = '0;
        col_pos    = '0;
        row_pos    = '0;
        seg_open   = 1'b0;
        seg_first  = '0;
        fg_last    = '0;
        gap_run    = '0;
        closed_cnt = '0;
        dropped    = 1'b0;
    endfunction

    function automatic void emit(input int s, input int e, input bit v, input bit l);
        t_seg_res res;
        res.seg_start = s[9:0];
        res.seg_end   = e[9:0];
        res.seg_valid = v;
        res.seg_last  = l;
        res.overflow  = dropped;
        owed_segs = {owed_segs, res};
    endfunction

    function automatic int padded_first();
        int b;
        int p;
        b = seg_first;
        p = r_pad;
        return (b >= p) ? b - p : 0;
    endfunction

    // Advance the gap tracker by one line; close a segment on a long enough gap
    function automatic void take_line(input int idx, input bit lit);
        int mg;
        int e;
        mg = (r_min_gap == 0) ? 1 : int'(r_min_gap);
        if (lit) begin
            if (!seg_open) begin
                seg_open  = 1'b1;
                seg_first = idx[9:0];
            end else if (int'(gap_run) >= mg) begin
                if (closed_cnt < MAX_CLOSED) begin
                    e = int'(fg_last) + int'(r_pad);
                    if (e > idx) e = idx;
                    emit(padded_first(), e, 1'b1, 1'b0);
                    closed_cnt = closed_cnt + 1'b1;
                end else begin
                    dropped = 1'b1;
                end
                seg_first = idx[9:0];
            end
            fg_last = idx[9:0];
            gap_run = '0;
        end else if (seg_open && gap_run < GAP_SAT) begin
            gap_run = gap_run + 1'b1;
        end
    endfunction

    // Emit the final segment of the image, or a bare end marker
    function automatic void end_image(input int total);
        int e;
        if (seg_open && total > 0 &&
            int'(fg_last) - int'(seg_first) + 1 >= int'(r_min_last)) begin
            e = int'(fg_last) + int'(r_pad);
            if (e > total - 1) e = total - 1;
            emit(padded_first(), e, 1'b1, 1'b1);
        end else begin
            emit(0, 0, 1'b0, 1'b1);
        end
    endfunction

    // Predict the segments that one pixel request causes
    function automatic void take_pixel(input t_pix_req req);
        int w;
        int total;
        w = (r_width > MAX_WIDTH) ? MAX_WIDTH : int'(r_width);
        if (row_pos < MAX_HEIGHT && col_pos < w && req.pixel_gray <= r_thr) begin
            if (r_dir) col_fg[col_pos] = col_fg[col_pos] + 1'b1;
            else       row_fg = row_fg + 1'b1;
        end
        if (col_pos < MAX_WIDTH) col_pos = col_pos + 1'b1;

        if (req.row_done || req.image_done) begin
            if (!r_dir && row_pos < MAX_HEIGHT) take_line(row_pos, row_fg != 0);
            row_fg  = '0;
            col_pos = '0;
            if (row_pos < MAX_HEIGHT) row_pos = row_pos + 1'b1;
        end

        if (req.image_done) begin
            if (r_dir) begin
                for (int c = 0; c < w; c++) take_line(c, col_fg[c] != 0);
                total = w;
            end else begin
                total = row_pos;
            end
            end_image(total);
            clear_image();
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_seg_res want;
        if (!i_rst_n) begin
            r_dir      = RST_DIRECTION;
            r_width    = RST_IMAGE_WIDTH;
            r_thr      = RST_FG_THRESHOLD;
            r_min_gap  = RST_MIN_GAP;
            r_min_last = RST_MIN_LAST;
            r_pad      = RST_EDGE_PAD;
            clear_image();
            owed_segs.delete();
            o_err_cnt  = 0;
        end else begin
            // Compare the strobed segment with the oldest prediction
            if (i_res_strobe) begin
                if (owed_segs.size() == 0) begin
                    o_err_cnt++;
                    $display("%0t: unexpected segment, expected none, got %s",
                             $time, seg_text(i_res));
                end else begin
                    want = owed_segs.pop_front();
                    if (i_res.seg_start !== want.seg_start ||
                        i_res.seg_end   !== want.seg_end   ||
                        i_res.seg_valid !== want.seg_valid ||
                        i_res.seg_last  !== want.seg_last  ||
                        i_res.overflow  !== want.overflow) begin
                        o_err_cnt++;
                        $display("%0t: segment mismatch, expected %s, got %s",
                                 $time, seg_text(want), seg_text(i_res));
                    end
                end
            end

            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DIRECTION:    r_dir      = i_cfg_data[0];
                    CFG_IMAGE_WIDTH:  r_width    = i_cfg_data;
                    CFG_FG_THRESHOLD: r_thr      = i_cfg_data[7:0];
                    CFG_MIN_GAP:      r_min_gap  = i_cfg_data;
                    CFG_MIN_LAST:     r_min_last = i_cfg_data;
                    CFG_EDGE_PAD:     r_pad      = i_cfg_data[3:0];
                    default: ;
                endcase
            end

            // Predict from each accepted pixel request
            if (i_start && !i_busy) take_pixel(i_req);
        end
        o_seg_owed = owed_segs.size();
    end

endmodule

@@ test/projection_profile_gap_segmenter_top_test.sv @@
module projection_profile_gap_segmenter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ppgs_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = MAX_WIDTH + 16;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    t_pix_req              i_req      = '0;
    t_seg_res              o_res;
    logic                  o_res_strobe;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int err_cnt;
    int seg_owed;
    int quiet_cycles = 0;

    // Shadows of the registers, used to shape the pixels
    bit cur_dir   = RST_DIRECTION;
    int cur_width = RST_IMAGE_WIDTH;
    int cur_thr   = RST_FG_THRESHOLD;
    int cur_gap   = RST_MIN_GAP;
    bit no_idle   = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    projection_profile_gap_segmenter_top #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    projection_profile_gap_segmenter_check #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_res        (o_res),
        .i_res_strobe (o_res_strobe),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_err_cnt    (err_cnt),
        .o_seg_owed   (seg_owed)
    );

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_strobe) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[projection_profile_gap_segmenter_top] ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] fg_gray();
        return 8'($urandom_range(0, cur_thr));
    endfunction

    function automatic logic [7:0] bg_gray();
        return (cur_thr >= 255) ? 8'd255 : 8'($urandom_range(cur_thr + 1, 255));
    endfunction

    // Present one pixel request after a random gap and hold it until taken
    task automatic put_pixel(input logic [7:0] gray, input logic rd, input logic idn);
        t_pix_req px;
        int       gap;
        px.pixel_gray = gray;
        px.row_done   = rd;
        px.image_done = idn;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= px;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Drop start and hold off until every predicted segment has arrived
    task automatic hold_for_results();
        start <= 1'b0;
        do @(negedge i_clk); while (seg_owed != 0);
    endtask

    // Wait for the block to go idle before touching the registers
    task automatic settle();
        hold_for_results();
        repeat (8) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_DIRECTION:    cur_dir   = val[0];
            CFG_IMAGE_WIDTH:  cur_width = val;
            CFG_FG_THRESHOLD: cur_thr   = val;
            CFG_MIN_GAP:      cur_gap   = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Draw a full register setting, extremes included
    task automatic pick_config();
        int w;
        int t;
        int g;
        int l;
        case ($urandom_range(0, 9))
            0:       w = 0;
            1:       w = 1;
            2:       w = MAX_WIDTH;
            3:       w = $urandom_range(MAX_WIDTH + 1, 2047);
            default: w = $urandom_range(2, 12);
        endcase
        case ($urandom_range(0, 5))
            0:       t = 0;
            1:       t = 255;
            default: t = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 9))
            0:       g = 0;
            1:       g = 1024;
            2:       g = 2047;
            default: g = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 9))
            0:       l = 0;
            1:       l = 1024;
            2:       l = 2047;
            default: l = $urandom_range(1, 4);
        endcase
        set_reg(CFG_DIRECTION, $urandom_range(0, 1));
        set_reg(CFG_IMAGE_WIDTH, w);
        set_reg(CFG_FG_THRESHOLD, t);
        set_reg(CFG_MIN_GAP, g);
        set_reg(CFG_MIN_LAST, l);
        set_reg(CFG_EDGE_PAD, $urandom_range(0, 15));
    endtask

    // Send one image whose lines follow runs of empty and lit lines
    task automatic send_image(input int rows, input int cols, input bit noisy,
                              input bit pause_mid);
        bit         lit [];
        int         n_lines;
        int         i;
        int         k;
        int         run;
        int         sent;
        bit         fg;
        logic [7:0] g;
        logic       rd;
        logic       idn;
        n_lines = cur_dir ? cols : rows;
        lit = new[n_lines];
        i = 0;
        while (i < n_lines) begin
            run = $urandom_range(0, ((cur_gap > 10) ? 10 : cur_gap) + 2);
            for (k = 0; k < run && i < n_lines; k++) begin
                lit[i] = 1'b0;
                i = i + 1;
            end
            run = $urandom_range(1, 3);
            for (k = 0; k < run && i < n_lines; k++) begin
                lit[i] = 1'b1;
                i = i + 1;
            end
        end

        sent = 0;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (cur_dir) fg = lit[c] && (r == rows - 1 || $urandom_range(0, 1));
                else         fg = lit[r] && (c == 0 || $urandom_range(0, 1));
                g = fg ? fg_gray() : bg_gray();
                if (noisy && $urandom_range(0, 9) == 0) g = 8'($urandom_range(0, 255));
                idn = (r == rows - 1 && c == cols - 1);
                rd  = (c == cols - 1) ? (idn ? 1'($urandom_range(0, 1)) : 1'b1) : 1'b0;
                // Break the row or the image early now and then
                if (noisy && !idn && $urandom_range(0, 15) == 0) rd = 1'b1;
                if (noisy && !idn && $urandom_range(0, 31) == 0) idn = 1'b1;
                put_pixel(g, rd, idn);
                if (idn) return;
                sent = sent + 1;
                if (pause_mid && sent == (rows * cols) / 2) hold_for_results();
            end
        end
    endtask

    initial begin : stimulus
        int rows;
        int cols;
        int n_img;
        int rand_items;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Empty image under the reset setting
        put_pixel(8'd255, 1'b0, 1'b1);
        settle();

        // Threshold edges; final segment shorter than min_last is dropped
        put_pixel(8'd0, 1'b1, 1'b0);
        put_pixel(8'd125, 1'b1, 1'b0);
        put_pixel(8'd126, 1'b0, 1'b1);
        settle();

        // Zero min_gap acts as one; wide padding clamps at both ends
        set_reg(CFG_MIN_GAP, 0);
        set_reg(CFG_MIN_LAST, 1);
        set_reg(CFG_EDGE_PAD, 15);
        i_cfg_we <= 1'b0;
        put_pixel(8'd0, 1'b1, 1'b0);
        put_pixel(8'd255, 1'b1, 1'b0);
        put_pixel(8'd0, 1'b1, 1'b0);
        put_pixel(8'd255, 1'b1, 1'b1);
        settle();

        // Column mode with a split between columns one and three
        set_reg(CFG_DIRECTION, 1);
        set_reg(CFG_IMAGE_WIDTH, 4);
        set_reg(CFG_FG_THRESHOLD, 0);
        i_cfg_we <= 1'b0;
        put_pixel(8'd0, 1'b0, 1'b0);
        put_pixel(8'd255, 1'b0, 1'b0);
        put_pixel(8'd255, 1'b0, 1'b0);
        put_pixel(8'd0, 1'b1, 1'b0);
        put_pixel(8'd255, 1'b0, 1'b0);
        put_pixel(8'd0, 1'b0, 1'b0);
        put_pixel(8'd255, 1'b0, 1'b0);
        put_pixel(8'd255, 1'b0, 1'b1);
        settle();

        // Foreground beyond the used width is ignored
        set_reg(CFG_DIRECTION, 0);
        set_reg(CFG_IMAGE_WIDTH, 2);
        set_reg(CFG_FG_THRESHOLD, 128);
        i_cfg_we <= 1'b0;
        put_pixel(8'd200, 1'b0, 1'b0);
        put_pixel(8'd200, 1'b0, 1'b0);
        put_pixel(8'd0, 1'b0, 1'b0);
        put_pixel(8'd0, 1'b1, 1'b0);
        put_pixel(8'd255, 1'b0, 1'b0);
        put_pixel(8'd255, 1'b0, 1'b1);
        settle();

        // Width zero in column mode ignores every pixel
        set_reg(CFG_DIRECTION, 1);
        set_reg(CFG_IMAGE_WIDTH, 0);
        i_cfg_we <= 1'b0;
        put_pixel(8'd0, 1'b1, 1'b1);

        // Random images, each under a fresh setting
        n_img = 0;
        rand_items = 0;
        while (rand_items < 240) begin
            settle();
            pick_config();
            no_idle = ($urandom_range(0, 3) == 0);
            case (n_img)
                3: begin
                    // More closed segments than the budget allows
                    set_reg(CFG_DIRECTION, 0);
                    set_reg(CFG_IMAGE_WIDTH, 1);
                    set_reg(CFG_MIN_GAP, 1);
                    i_cfg_we <= 1'b0;
                    for (int r = 0; r < 140; r++)
                        put_pixel((r % 2 == 0) ? fg_gray() : bg_gray(), 1'b1, r == 139);
                end
                default: begin
                    i_cfg_we <= 1'b0;
                    rows = $urandom_range(1, 8);
                    if (cur_width <= 12) cols = $urandom_range(1, cur_width + 2);
                    else                 cols = $urandom_range(1, 8);
                    send_image(rows, cols, $urandom_range(0, 4) == 0,
                               n_img == 1 || $urandom_range(0, 7) == 0);
                    rand_items = rand_items + rows * cols;
                end
            endcase
            n_img = n_img + 1;
        end

        // Drain and give the verdict
        hold_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_cnt == 0)
            $display("[projection_profile_gap_segmenter_top] OK");
        else
            $display("[projection_profile_gap_segmenter_top] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ppgs_pkg.sv
hdl/ppgs_ctrl.sv
hdl/ppgs_dp.sv
hdl/projection_profile_gap_segmenter_top.sv
test/projection_profile_gap_segmenter_check.sv
test/projection_profile_gap_segmenter_top_test.sv
